[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions, all sampled on clk and off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/sco_pkg.sv]
// ----------------------------------------------------------------------------
// sco_pkg
// Shared constants and types of the moving-average crossover order signal.
// ----------------------------------------------------------------------------
`default_nettype none

package sco_pkg;

  // Default window lengths and price width.
  localparam int unsigned LONG_LEN_DEF   = 20;
  localparam int unsigned SHORT_LEN_DEF  = 5;
  localparam int unsigned PRICE_BITS_DEF = 50;

  // Widest price the design supports; the constants below are held at it.
  localparam int unsigned MAX_PRICE_BITS = 60;
  localparam int unsigned QTY_W          = 4;

  // First value of the windows after reset; entry i holds WINDOW_BASE + i.
  localparam int unsigned WINDOW_BASE = 100;

  // The "no ask" marker and the prices that stand in for it.
  localparam logic [MAX_PRICE_BITS-1:0] NO_ASK            = 60'd1000000000000000;
  localparam logic [MAX_PRICE_BITS-1:0] BUY_NO_ASK_PRICE  = 60'd999999999999000;
  localparam logic [MAX_PRICE_BITS-1:0] SELL_NO_ASK_PRICE = 60'd125;

  // Order side codes.
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  // Outcome of the mean comparison.
  typedef struct packed {
    logic fire;   // means differ, an order goes out
    logic side;   // SIDE_BUY or SIDE_SELL
  } verdict_t;

endpackage

`default_nettype wire

[sv/sco_window.sv]
// ----------------------------------------------------------------------------
// sco_window
// Shift line of the most recent prices with a running sum over it.
// ----------------------------------------------------------------------------
`default_nettype none

module sco_window
  import sco_pkg::*;
#(
  parameter int unsigned LEN        = LONG_LEN_DEF,
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF,
  localparam int unsigned SUM_W     = PRICE_BITS + $clog2(LEN)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [PRICE_BITS-1:0] price,
  output logic      [SUM_W-1:0]      sum
);

  localparam int unsigned SUM_RESET = LEN * WINDOW_BASE + (LEN * (LEN - 1)) / 2;

  // Entry 0 is the oldest price.
  logic [PRICE_BITS-1:0] win [LEN];
  logic [SUM_W-1:0]      sum_next;

  assign sum_next = sum + SUM_W'(price) - SUM_W'(win[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEN; i++) begin
        win[i] <= PRICE_BITS'(WINDOW_BASE + i);
      end
      sum <= SUM_W'(SUM_RESET);
    end else if (push) begin
      for (int i = 0; i < LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[LEN-1] <= price;
      sum        <= sum_next;
    end
  end

endmodule

`default_nettype wire

[sv/sco_decide.sv]
// ----------------------------------------------------------------------------
// sco_decide
// Exact comparison of the two means and choice of the order price.
// ----------------------------------------------------------------------------
`default_nettype none

module sco_decide
  import sco_pkg::*;
#(
  parameter int unsigned LONG_LEN    = LONG_LEN_DEF,
  parameter int unsigned SHORT_LEN   = SHORT_LEN_DEF,
  parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
  localparam int unsigned LSUM_W     = PRICE_BITS + $clog2(LONG_LEN),
  localparam int unsigned SSUM_W     = PRICE_BITS + $clog2(SHORT_LEN)
) (
  input  wire logic [SSUM_W-1:0]     short_sum,
  input  wire logic [LSUM_W-1:0]     long_sum,
  input  wire logic [PRICE_BITS-1:0] price,
  output verdict_t                   verdict,
  output logic      [PRICE_BITS-1:0] order_price
);

  // Both scaled sums stay below LONG_LEN * SHORT_LEN * 2^PRICE_BITS.
  localparam int unsigned CMP_W = PRICE_BITS + $clog2(LONG_LEN * SHORT_LEN);

  logic [CMP_W-1:0] short_scaled;
  logic [CMP_W-1:0] long_scaled;
  logic             no_ask;

  // Multiplying by a small constant: shifts and adds in synthesis.
  assign short_scaled = CMP_W'(short_sum) * CMP_W'(LONG_LEN);
  assign long_scaled  = CMP_W'(long_sum) * CMP_W'(SHORT_LEN);

  assign verdict.fire = (short_scaled != long_scaled);
  assign verdict.side = (short_scaled > long_scaled) ? SIDE_BUY : SIDE_SELL;

  assign no_ask = (price == PRICE_BITS'(NO_ASK));

  always_comb begin
    if (!no_ask) begin
      order_price = price;
    end else if (verdict.side == SIDE_BUY) begin
      order_price = PRICE_BITS'(BUY_NO_ASK_PRICE);
    end else begin
      order_price = PRICE_BITS'(SELL_NO_ASK_PRICE);
    end
  end

endmodule

`default_nettype wire

[sv/sma_crossover_order_signal_core.sv]
// ----------------------------------------------------------------------------
// sma_crossover_order_signal_core
// Moving-average crossover of best-ask prices, issuing buy and sell orders.
// ----------------------------------------------------------------------------
// Use of the block:
// Each word on the s_axis channel carries one best-ask price and the quantity
// to attach to any order it causes. A price equal to the previous new price is
// dropped. A new price is pushed into a long and a short window, each kept as
// a shift line with a running sum. When the short mean is above the long mean
// a buy order word leaves on m_axis, when below a sell order word; on equal
// means the windows move on but no word is sent. The "no ask" price enters
// the windows as it is and only the order price is replaced.
// Timing: a word accepted at a clock edge is held in the input register; from
// there it updates the windows and sums as it moves into the b stage, and the
// resulting order is then loaded into the result register, from which it is
// offered on m_axis. A new word can be taken at every edge unless an order
// is held back on m_axis; updating the sums in one step allows that rate.
// Reset (synchronous, active high) loads the windows with 100, 101, ... and
// forgets the previous price, so the first word after reset always counts.
// Back-pressure: while an order waits on m_axis and m_axis_tready is low, the
// whole pipeline holds and s_axis_tready is low; when the waiting order is
// taken, a new word may be taken at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sma_crossover_order_signal_core
  import sco_pkg::*;
#(
  parameter int unsigned LONG_LEN    = LONG_LEN_DEF,
  parameter int unsigned SHORT_LEN   = SHORT_LEN_DEF,
  parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
  localparam int unsigned DATA_W     = ((PRICE_BITS + QTY_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Price input channel.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,  // ask price, order quantity, zero pad
  // Order output channel.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [DATA_W-1:0] m_axis_tdata,  // order_price, order_size, zero pad
  output logic                   m_axis_tuser   // order_side
);

  localparam int unsigned LSUM_W = PRICE_BITS + $clog2(LONG_LEN);
  localparam int unsigned SSUM_W = PRICE_BITS + $clog2(SHORT_LEN);

  // Pipeline advance: everything moves unless a finished order is stuck.
  logic en;

  // Input register.
  logic                  a_valid;
  logic [PRICE_BITS-1:0] a_price;
  logic [QTY_W-1:0]      a_qty;

  // Previous new price.
  logic                  have_last;
  logic [PRICE_BITS-1:0] last_price;
  logic                  push;

  // Item whose window update has just been made.
  logic                  b_valid;
  logic [PRICE_BITS-1:0] b_price;
  logic [QTY_W-1:0]      b_qty;

  // Result register.
  logic                  res_valid;
  logic                  res_side;
  logic [PRICE_BITS-1:0] res_price;
  logic [QTY_W-1:0]      res_qty;

  logic [LSUM_W-1:0]     long_sum;
  logic [SSUM_W-1:0]     short_sum;
  verdict_t              verdict;
  logic [PRICE_BITS-1:0] order_price;

  // Conditions watched by the assertions at the end.
  logic                  a_repeat;
  logic                  b_tie;
  logic                  out_stall;

  assign en            = !res_valid || m_axis_tready;
  assign s_axis_tready = en;

  // A price counts only when it differs from the last counted one.
  assign push = en && a_valid && (!have_last || (a_price != last_price));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      have_last  <= 1'b0;
      last_price <= '0;
      b_valid    <= 1'b0;
      res_valid  <= 1'b0;
    end else if (en) begin
      a_valid   <= s_axis_tvalid;
      b_valid   <= push;
      res_valid <= b_valid && verdict.fire;
      if (push) begin
        have_last  <= 1'b1;
        last_price <= a_price;
      end
    end
  end

  // Payload registers move with the pipeline and need no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      a_price   <= s_axis_tdata[PRICE_BITS-1:0];
      a_qty     <= s_axis_tdata[PRICE_BITS +: QTY_W];
      b_price   <= a_price;
      b_qty     <= a_qty;
      res_side  <= verdict.side;
      res_price <= order_price;
      res_qty   <= b_qty;
    end
  end

  sco_window #(
    .LEN        (LONG_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_long_window (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .price (a_price),
    .sum   (long_sum)
  );

  sco_window #(
    .LEN        (SHORT_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_short_window (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .price (a_price),
    .sum   (short_sum)
  );

  // The sums seen here already include the item held in the b stage.
  sco_decide #(
    .LONG_LEN   (LONG_LEN),
    .SHORT_LEN  (SHORT_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_decide (
    .short_sum   (short_sum),
    .long_sum    (long_sum),
    .price       (b_price),
    .verdict     (verdict),
    .order_price (order_price)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_side;
  assign m_axis_tdata  = DATA_W'({res_qty, res_price});

  assign a_repeat  = en && a_valid && have_last && (a_price == last_price);
  assign b_tie     = en && b_valid && !verdict.fire;
  assign out_stall = res_valid && !m_axis_tready;

  // A repeated price never reaches the decision stage.
  `ASSERT_AT_CLK(a_repeat_dropped, a_repeat |=> !b_valid, "repeated price passed on")
  // Equal means give no order.
  `ASSERT_AT_CLK(a_tie_silent, b_tie |=> !res_valid, "order issued on equal means")
  // No word is taken while a finished order is held back.
  `ASSERT_NEVER(a_ready_when_blocked, out_stall && s_axis_tready, "input ready while stalled")

endmodule

`default_nettype wire

[tb/tb_sma_crossover_order_signal_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sma_crossover_order_signal_core
// Self-checking bench for the 5/20 moving-average crossover order signal.
// ----------------------------------------------------------------------------
// Ask prices are streamed into the block with bursty valid and a receiver that
// stalls on its own schedule. A local model of both windows and their running
// sums predicts every order word, which is checked field by field as it
// leaves. A short directed opening covers the edge cases. Random episodes of
// drifting, wide, high and low prices with repeats and no-ask words follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sma_crossover_order_signal_core;
  import sco_pkg::*;

  localparam int unsigned PRICE_W = PRICE_BITS_DEF;
  localparam int unsigned LONG_N  = LONG_LEN_DEF;
  localparam int unsigned SHORT_N = SHORT_LEN_DEF;
  localparam int unsigned DATA_W  = ((PRICE_W + QTY_W + 7) / 8) * 8;
  localparam int unsigned PAD_W   = DATA_W - PRICE_W - QTY_W;

  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [PRICE_W-1:0] NO_ASK_P  = NO_ASK[PRICE_W-1:0];
  localparam logic [PRICE_W-1:0] BUY_SUB   = BUY_NO_ASK_PRICE[PRICE_W-1:0];
  localparam logic [PRICE_W-1:0] SELL_SUB  = SELL_NO_ASK_PRICE[PRICE_W-1:0];

  // Number of price words, repeats included, the stimulus aims for.
  localparam int unsigned WORD_TARGET = 1950;
  // Cycles allowed after the last expected order for stray words to show up.
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] ask;
  } ask_word_t;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   size;
  } order_word_t;

  // Random episode flavours.
  typedef enum int unsigned {
    EP_WIDE,   // uniformly random over the whole price range
    EP_DRIFT,  // random walk with large steps
    EP_HIGH,   // close to the top of the range, so no-ask words give sells
    EP_LOW     // tiny prices, many repeats and equal means
  } episode_e;

  // Receiver stall flavours.
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SELDOM,
    RX_PATTERN
  } rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // ask price, order quantity, zero pad
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // order_price, order_size, zero pad
  logic              m_axis_tuser;        // order_side

  sma_crossover_order_signal_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Crossover predictor: its own copy of both windows and running sums.
  // The sums are held at 64 bits, wide enough that neither they nor their
  // scaled forms can wrap at a 50-bit price.
  // --------------------------------------------------------------------------
  logic [PRICE_W-1:0] prev_ask;
  logic               prev_ask_valid;
  logic [PRICE_W-1:0] long_win [LONG_N];
  logic [PRICE_W-1:0] short_win[SHORT_N];
  int unsigned        long_head;
  int unsigned        short_head;
  logic [63:0]        long_total;
  logic [63:0]        short_total;

  order_word_t expected_orders[$];

  int unsigned dup_drops;
  int unsigned flat_means;
  int unsigned buy_orders;
  int unsigned sell_orders;
  int unsigned no_ask_buys;
  int unsigned no_ask_sells;
  int unsigned words_taken;
  int unsigned orders_checked;
  int unsigned mismatch_count;

  task automatic clear_windows();
    prev_ask       = '0;
    prev_ask_valid = 1'b0;
    long_head      = 0;
    short_head     = 0;
    long_total     = '0;
    short_total    = '0;
    for (int i = 0; i < LONG_N; i++) begin
      long_win[i] = PRICE_W'(WINDOW_BASE + i);
      long_total  = long_total + long_win[i];
    end
    for (int i = 0; i < SHORT_N; i++) begin
      short_win[i] = PRICE_W'(WINDOW_BASE + i);
      short_total  = short_total + short_win[i];
    end
  endtask

  // Applies one accepted ask word and queues the order it should produce.
  task automatic apply_ask(input ask_word_t w);
    logic [63:0] short_scaled;
    logic [63:0] long_scaled;
    order_word_t order;

    words_taken++;
    if (prev_ask_valid && w.ask == prev_ask) begin
      dup_drops++;
      return;
    end
    prev_ask_valid = 1'b1;
    prev_ask       = w.ask;

    // The head points at the oldest entry, which the new price replaces.
    long_total          = long_total + w.ask - long_win[long_head];
    long_win[long_head] = w.ask;
    long_head           = (long_head + 1 < LONG_N) ? long_head + 1 : 0;

    short_total           = short_total + w.ask - short_win[short_head];
    short_win[short_head] = w.ask;
    short_head            = (short_head + 1 < SHORT_N) ? short_head + 1 : 0;

    // Means compared exactly by cross-multiplying with the other length.
    short_scaled = short_total * LONG_N;
    long_scaled  = long_total * SHORT_N;
    if (short_scaled == long_scaled) begin
      flat_means++;
      return;
    end

    order.size = w.qty;
    if (short_scaled > long_scaled) begin
      order.side  = SIDE_BUY;
      order.price = (w.ask == NO_ASK_P) ? BUY_SUB : w.ask;
      buy_orders++;
      if (w.ask == NO_ASK_P) no_ask_buys++;
    end else begin
      order.side  = SIDE_SELL;
      order.price = (w.ask == NO_ASK_P) ? SELL_SUB : w.ask;
      sell_orders++;
      if (w.ask == NO_ASK_P) no_ask_sells++;
    end
    expected_orders.insert(expected_orders.size(), order);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: words go out in bursts of random length separated by random gaps.
  // A word stays on the bus unchanged until it has been taken.
  // --------------------------------------------------------------------------
  ask_word_t   ask_stream[$];
  ask_word_t   on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      clear_windows();
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_ask(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (ask_stream.size() != 0) begin
          on_bus = ask_stream[0];
          ask_stream.delete(0);
          s_axis_tdata  <= {{PAD_W{1'b0}}, on_bus.qty, on_bus.ask};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Pick the next burst and the pause in front of it; a third of
            // the time there is no pause, a third a short one that may be empty.
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(0, 3);
              default: gap_left = $urandom_range(1, 20);
            endcase
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each order word against the oldest prediction, and
  // drives a ready that runs through several stall patterns of its own.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode     = RX_ALWAYS;
  int unsigned rx_left     = 0;
  int unsigned rx_cycle_no = 0;

  always @(posedge clk) begin
    order_word_t want;
    logic        ready_next;

    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        orders_checked++;
        if (expected_orders.size() == 0) begin
          report_mismatch($sformatf("unexpected order: side %0b price %0d size %0d",
                                    m_axis_tuser, m_axis_tdata[PRICE_W-1:0],
                                    m_axis_tdata[PRICE_W +: QTY_W]));
        end else begin
          want = expected_orders[0];
          expected_orders.delete(0);
          if (m_axis_tuser !== want.side)
            report_mismatch($sformatf("order side %0b, expected %0b",
                                      m_axis_tuser, want.side));
          if (m_axis_tdata[PRICE_W-1:0] !== want.price)
            report_mismatch($sformatf("order price %0d, expected %0d",
                                      m_axis_tdata[PRICE_W-1:0], want.price));
          if (m_axis_tdata[PRICE_W +: QTY_W] !== want.size)
            report_mismatch($sformatf("order size %0d, expected %0d",
                                      m_axis_tdata[PRICE_W +: QTY_W], want.size));
          if (m_axis_tdata[DATA_W-1:PRICE_W+QTY_W] !== '0)
            report_mismatch($sformatf("order pad bits %b are not zero",
                                      m_axis_tdata[DATA_W-1:PRICE_W+QTY_W]));
        end
      end

      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 256);
      end else begin
        rx_left--;
      end
      rx_cycle_no++;
      case (rx_mode)
        RX_ALWAYS: ready_next = 1'b1;
        RX_MOSTLY: ready_next = ($urandom_range(0, 9) < 7);
        RX_SELDOM: ready_next = ($urandom_range(0, 9) < 3);
        default:   ready_next = ((rx_cycle_no % 7) < 3);
      endcase
      m_axis_tready <= ready_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [PRICE_W-1:0] gen_prev;
  logic               gen_prev_valid = 1'b0;

  // Queues one word and remembers it so that repeats can be made.
  task automatic queue_ask(input logic [PRICE_W-1:0] ask, input logic [QTY_W-1:0] qty);
    ask_word_t w;
    w.ask = ask;
    w.qty = qty;
    gen_prev       = ask;
    gen_prev_valid = 1'b1;
    ask_stream.insert(ask_stream.size(), w);
  endtask

  function automatic logic [PRICE_W-1:0] wide_price();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[PRICE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] nudge(input logic [PRICE_W-1:0] level,
                                                input logic [PRICE_W-1:0] step);
    if ($urandom_range(0, 1) == 0) return (level > step) ? level - step : '0;
    return (PRICE_MAX - level > step) ? level + step : PRICE_MAX;
  endfunction

  initial begin : stimulus
    episode_e           kind;
    int unsigned        span;
    int unsigned        roll;
    logic [PRICE_W-1:0] level;
    logic [PRICE_W-1:0] ask;
    logic [QTY_W-1:0]   qty;

    // The first word is zero, which matches the cleared last price yet must
    // still count as new and give a sell at zero with a zero quantity.
    queue_ask('0, 4'd0);
    queue_ask('0, 4'd1);                // repeat: dropped
    // From that state a price of 251 makes both means exactly equal.
    queue_ask(PRICE_W'(251), 4'd2);
    queue_ask(PRICE_W'(251), 4'd3);     // repeat: dropped
    queue_ask(PRICE_MAX, 4'd15);
    queue_ask(PRICE_MAX - 1'b1, 4'd11);
    // No ask with the short mean on top: buy at the substitute price.
    queue_ask(NO_ASK_P, 4'd12);
    queue_ask(NO_ASK_P, 4'd13);         // repeat: dropped
    // Falling prices pull the short mean under the long one.
    queue_ask(PRICE_W'(1), 4'd14);
    queue_ask('0, 4'd4);
    queue_ask(PRICE_W'(1), 4'd5);
    queue_ask('0, 4'd6);
    queue_ask(PRICE_W'(1), 4'd7);
    queue_ask('0, 4'd8);
    queue_ask(50'h2AAAAAAAAAAAA, 4'd9);
    queue_ask(50'h1555555555555, 4'd10);

    // Random episodes. Repeats and no-ask words are sprinkled into each.
    while (ask_stream.size() < WORD_TARGET) begin
      kind = episode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      case (kind)
        EP_HIGH: level = PRICE_MAX - PRICE_W'($urandom_range(0, 5000));
        EP_LOW:  level = PRICE_W'($urandom_range(0, 400));
        default: level = wide_price();
      endcase
      for (int k = 0; k < span; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12 && gen_prev_valid) begin
          ask = gen_prev;
        end else if (roll < 19) begin
          ask = NO_ASK_P;
        end else begin
          case (kind)
            EP_WIDE:  ask = wide_price();
            EP_DRIFT: begin
              level = nudge(level, PRICE_W'($urandom_range(0, 1 << 20)));
              ask   = level;
            end
            EP_HIGH:  begin
              level = nudge(level, PRICE_W'($urandom_range(0, 300)));
              ask   = level;
            end
            default:  ask = PRICE_W'($urandom_range(0, 400));
          endcase
        end
        if ($urandom_range(0, 9) == 0) qty = QTY_W'($urandom_range(0, 15));
        else                           qty = QTY_W'($urandom_range(1, 10));
        queue_ask(ask, qty);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: every word taken and every predicted order seen.
    do @(negedge clk);
    while (ask_stream.size() != 0 || s_axis_tvalid || expected_orders.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_orders.size() != 0)
      report_mismatch($sformatf("%0d orders never arrived", expected_orders.size()));

    $display("Run covered %0d price words: %0d repeats dropped, %0d with equal means.",
             words_taken, dup_drops, flat_means);
    $display("Orders checked: %0d (%0d buys, %0d sells; no-ask substituted %0d/%0d).",
             orders_checked, buy_orders, sell_orders, no_ask_buys, no_ask_sells);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[sma_crossover_order_signal_core.f]
+incdir+sv
sv/sco_pkg.sv
sv/sco_window.sv
sv/sco_decide.sv
sv/sma_crossover_order_signal_core.sv
tb/tb_sma_crossover_order_signal_core.sv
